/* src/olk_pkg.sv */
package olk_pkg;

  localparam int unsigned KeyW          = 16;
  localparam int unsigned LayerW        = 5;
  localparam int unsigned TickW         = 16;
  localparam int unsigned MaskW         = 4;
  localparam int unsigned CfgDataW      = 21;
  localparam int unsigned CfgIdxW       = 3;
  localparam int unsigned NumEntryRegs  = 4;
  localparam int unsigned DefaultLayers = 4;
  localparam int unsigned QueueDepth    = 2;

  localparam logic [CfgIdxW-1:0] WaitRegIdx = 3'd4;
  localparam logic [TickW-1:0]   WaitReset  = 16'd500;

  // entry state, one-hot
  typedef enum logic [4:0] {
    MODE_UP          = 5'b00001,
    MODE_QUEUED      = 5'b00010,
    MODE_QUEUED_USED = 5'b00100,
    MODE_DOWN_UNUSED = 5'b01000,
    MODE_DOWN_USED   = 5'b10000
  } mode_e;

  typedef struct packed {
    logic [KeyW-1:0]   key_code;
    logic              is_press;
    logic [LayerW-1:0] source_layer;
    logic [TickW-1:0]  now_ticks;
  } in_t;

  typedef struct packed {
    logic             pass_through;
    logic [MaskW-1:0] layer_on_mask;
    logic [MaskW-1:0] layer_off_mask;
  } out_t;

  typedef struct packed {
    logic                en;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] data;
  } cfg_wr_t;

endpackage

/* src/olk_front.sv */
module olk_front #(
  parameter int unsigned Layers = olk_pkg::DefaultLayers
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  olk_pkg::cfg_wr_t     cfg_i,
  input  olk_pkg::in_t         in_data_i,
  output logic [Layers-1:0]    trig_hit_o,
  output logic [Layers-1:0]    layer_hit_o
);

  localparam int unsigned NumCfg = (Layers < olk_pkg::NumEntryRegs) ?
                                   Layers : olk_pkg::NumEntryRegs;
  localparam int unsigned IdxW   = olk_pkg::CfgIdxW;
  localparam int unsigned KeyW   = olk_pkg::KeyW;
  localparam int unsigned LayerW = olk_pkg::LayerW;

  for (genvar i = 0; i < Layers; i++) begin : g_entry
    logic [KeyW-1:0]   trig;
    logic [LayerW-1:0] layer;

    if (i < NumCfg) begin : g_cfg
      logic [olk_pkg::CfgDataW-1:0] cfg_q;

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          cfg_q <= '0;
        end else if (cfg_i.en && cfg_i.idx == IdxW'(i)) begin
          cfg_q <= cfg_i.data;
        end
      end

      assign trig  = cfg_q[LayerW +: KeyW];
      assign layer = cfg_q[LayerW-1:0];
    end else begin : g_fixed
      // entries without a register keep trigger 0 and layer 0
      assign trig  = '0;
      assign layer = '0;
    end

    assign trig_hit_o[i]  = (in_data_i.key_code == trig);
    assign layer_hit_o[i] = (in_data_i.source_layer == layer);
  end

endmodule

/* src/olk_fifo.sv */
module olk_fifo #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = olk_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [Width-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [Width-1:0] pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             push, pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* src/olk_back.sv */
module olk_back #(
  parameter int unsigned Layers = olk_pkg::DefaultLayers
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  olk_pkg::cfg_wr_t            cfg_i,
  input  logic                        q_valid_i,
  output logic                        q_ready_o,
  input  logic [Layers-1:0]           trig_hit_i,
  input  logic [Layers-1:0]           layer_hit_i,
  input  logic                        is_press_i,
  input  logic [olk_pkg::TickW-1:0]   now_ticks_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output olk_pkg::out_t               out_data_o
);

  localparam int unsigned TickW = olk_pkg::TickW;
  localparam int unsigned MaskW = olk_pkg::MaskW;

  logic [TickW-1:0]  wait_q;
  logic              out_valid_q;
  olk_pkg::out_t     out_q, out_d;
  logic              fire;
  logic [Layers-1:0] on_vec, off_vec, keep_vec;

  // output slot free or draining this cycle
  assign q_ready_o = !out_valid_q || out_ready_i;
  assign fire      = q_valid_i && q_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wait_q <= olk_pkg::WaitReset;
    end else if (cfg_i.en && cfg_i.idx == olk_pkg::WaitRegIdx) begin
      wait_q <= cfg_i.data[TickW-1:0];
    end
  end

  for (genvar i = 0; i < Layers; i++) begin : g_entry
    olk_pkg::mode_e   mode_q, mode_d;
    logic [TickW-1:0] stamp_q;
    logic [TickW-1:0] held;
    logic             stamp_we;

    assign held = now_ticks_i - stamp_q;

    always_comb begin
      mode_d      = mode_q;
      on_vec[i]   = 1'b0;
      off_vec[i]  = 1'b0;
      keep_vec[i] = 1'b1;
      stamp_we    = 1'b0;
      if (trig_hit_i[i]) begin
        if (is_press_i) begin
          on_vec[i]   = (mode_q == olk_pkg::MODE_UP);
          stamp_we    = 1'b1;
          mode_d      = olk_pkg::MODE_DOWN_UNUSED;
          keep_vec[i] = 1'b0;
        end else if (mode_q == olk_pkg::MODE_DOWN_UNUSED) begin
          keep_vec[i] = 1'b0;
          if (held > wait_q) begin
            mode_d     = olk_pkg::MODE_UP;
            off_vec[i] = 1'b1;
          end else begin
            mode_d = olk_pkg::MODE_QUEUED;
          end
        end else if (mode_q == olk_pkg::MODE_DOWN_USED) begin
          mode_d      = olk_pkg::MODE_UP;
          off_vec[i]  = 1'b1;
          keep_vec[i] = 1'b0;
        end
      end else if (layer_hit_i[i]) begin
        if (is_press_i) begin
          case (mode_q)
            olk_pkg::MODE_DOWN_UNUSED: mode_d = olk_pkg::MODE_DOWN_USED;
            olk_pkg::MODE_QUEUED:      mode_d = olk_pkg::MODE_QUEUED_USED;
            olk_pkg::MODE_QUEUED_USED: begin
              mode_d      = olk_pkg::MODE_UP;
              off_vec[i]  = 1'b1;
              keep_vec[i] = 1'b0;
            end
            default: mode_d = mode_q;
          endcase
        end else if (mode_q == olk_pkg::MODE_QUEUED ||
                     mode_q == olk_pkg::MODE_QUEUED_USED) begin
          mode_d     = olk_pkg::MODE_UP;
          off_vec[i] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        mode_q <= olk_pkg::MODE_UP;
      end else if (fire) begin
        mode_q <= mode_d;
      end
    end

    always_ff @(posedge clk_i) begin
      if (fire && stamp_we) begin
        stamp_q <= now_ticks_i;
      end
    end
  end

  always_comb begin
    out_d.pass_through = &keep_vec;
    for (int j = 0; j < MaskW; j++) begin
      out_d.layer_on_mask[j]  = (j < Layers) ? on_vec[j % Layers]  : 1'b0;
      out_d.layer_off_mask[j] = (j < Layers) ? off_vec[j % Layers] : 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (q_ready_o) begin
      out_valid_q <= q_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* src/one_shot_layer_key_fsm_core.sv */
// one-shot layer keys: each key event (keycode, press or release, source layer,
// timestamp) is matched against Layers entries, each holding a trigger keycode,
// a target layer and a small state machine (up, queued, queued and used, down
// unused, down used). One event gives one result: a pass flag and per-entry
// layer on and off masks (only entries 0 to 3 show in the masks). Events stream
// at one per cycle while the result output and the queue do not stall; the
// classify stage feeds a two-entry queue, and the entry update stage registers
// the result. Entry registers and the hold wait term are written through the
// plain write port and must only change while no event is in flight.
module one_shot_layer_key_fsm_core #(
  parameter int unsigned Layers = olk_pkg::DefaultLayers
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [olk_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [olk_pkg::CfgDataW-1:0]  cfg_wdata_i,
  // key events
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  olk_pkg::in_t                  in_data_i,
  // results
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output olk_pkg::out_t                 out_data_o
);

  localparam int unsigned TickW = olk_pkg::TickW;
  // queue word: trigger hits, layer hits, press flag, timestamp
  localparam int unsigned QW    = 2 * Layers + 1 + TickW;

  olk_pkg::cfg_wr_t  cfg;
  logic [Layers-1:0] trig_hit, layer_hit;
  logic [QW-1:0]     q_push_data, q_pop_data;
  logic              q_valid, q_ready;

  assign cfg.en   = cfg_we_i;
  assign cfg.idx  = cfg_idx_i;
  assign cfg.data = cfg_wdata_i;

  // front: compare the event against every entry's trigger and layer
  olk_front #(
    .Layers (Layers)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_data_i   (in_data_i),
    .trig_hit_o  (trig_hit),
    .layer_hit_o (layer_hit)
  );

  assign q_push_data = {trig_hit, layer_hit, in_data_i.is_press, in_data_i.now_ticks};

  // short queue decouples classification from the state update
  olk_fifo #(
    .Width (QW),
    .Depth (olk_pkg::QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_valid_i),
    .push_ready_o (in_ready_o),
    .push_data_i  (q_push_data),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_pop_data)
  );

  // back: entry state machines, press stamps and the result register
  olk_back #(
    .Layers (Layers)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .q_valid_i   (q_valid),
    .q_ready_o   (q_ready),
    .trig_hit_i  (q_pop_data[QW-1 -: Layers]),
    .layer_hit_i (q_pop_data[TickW+1 +: Layers]),
    .is_press_i  (q_pop_data[TickW]),
    .now_ticks_i (q_pop_data[TickW-1:0]),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
